FILE: hdl/iraf_pkg.sv
// Shared types, constants and codes of the IP address range access filter.
`default_nettype none

package iraf_pkg;

  // Rule table geometry.
  localparam int unsigned RULE_SLOTS = 16;
  localparam int unsigned IDX_W      = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int unsigned CNT_W      = $clog2(RULE_SLOTS + 1);

  // Command queue between front and back.
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Address widths.
  localparam int unsigned ADDR_W = 128;
  localparam int unsigned HALF_W = 64;
  localparam int unsigned V4_W   = 32;
  localparam int unsigned PLEN_W = 8;

  localparam logic [PLEN_W-1:0] PLEN_MAX_V4 = PLEN_W'(V4_W);
  localparam logic [PLEN_W-1:0] PLEN_MAX_V6 = PLEN_W'(ADDR_W);

  // Bits 63:32 of an IPv4-mapped IPv6 address (::ffff:a.b.c.d).
  localparam logic [V4_W-1:0] MAPPED_TAG = 32'h0000_ffff;

  typedef enum logic [1:0] {
    OP_CHECK      = 2'd0,
    OP_ADD_RANGE  = 2'd1,
    OP_ADD_PREFIX = 2'd2,
    OP_ALLOW_ALL  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_FULL       = 2'd1,
    STAT_BAD_PREFIX = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CMD_CHECK,
    CMD_ADD,
    CMD_REJECT,
    CMD_ALLOW
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_REPLY
  } state_e;

  // One inclusive range; for a check command lo holds the address.
  typedef struct packed {
    logic              family;
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
  } rule_t;

  typedef struct packed {
    cmd_e  kind;
    rule_t rule;
  } cmd_t;

endpackage

`default_nettype wire

FILE: hdl/ip_range_access_filter.sv
// Top level of the IP address range access filter.
// Items arrive on the s_axis channel; op and family travel in tuser, the
// addresses and prefix length in tdata. Every item yields one transfer on
// m_axis carrying the allowed flag and a status code.
// The front end normalises each item (IPv4 masking, mapped-address lookup,
// prefix expansion, range ordering) and queues it in a two-entry command
// queue, so s_axis keeps accepting while the back end is busy or a result
// waits to be taken.
// The back end walks the rule table one entry per cycle through a
// registered memory read. It takes the next command from the queue only
// once it has returned to idle. An add, reject, allow-all, or a check with
// allow-all set or an empty table, goes from idle through the reply state
// into the result register without a walk. A check that walks the table
// compares the rules up to a hit or the end of the table, at most
// RULE_SLOTS (sixteen), before it reaches the reply state.
// After reset the allow-all flag is set and the table is empty; no clearing
// pass is needed. When m_axis stalls the result is held in its register,
// the back end waits with the next result and the queue then fills, after
// which s_axis_tready drops.
`default_nettype none

module ip_range_access_filter (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // op [1:0], family [2]
  input  logic [2:0]   s_axis_tuser,
  // addr_hi [63:0], addr_lo [127:64], end_hi [191:128], end_lo [255:192],
  // prefix_len [263:256]
  input  logic [263:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // allowed [0], status [2:1], zero [7:3]
  output logic [7:0]   m_axis_tdata
);
  import iraf_pkg::*;

  logic       push;
  logic       full;
  logic       empty;
  logic       pop;
  cmd_t       push_cmd;
  cmd_t       head_cmd;
  logic       allowed;
  logic [1:0] status;

  iraf_front u_front (
    .valid_i      (s_axis_tvalid),
    .ready_o      (s_axis_tready),
    .op_i         (s_axis_tuser[1:0]),
    .family_i     (s_axis_tuser[2]),
    .addr_hi_i    (s_axis_tdata[63:0]),
    .addr_lo_i    (s_axis_tdata[127:64]),
    .end_hi_i     (s_axis_tdata[191:128]),
    .end_lo_i     (s_axis_tdata[255:192]),
    .prefix_len_i (s_axis_tdata[263:256]),
    .full_i       (full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  iraf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (head_cmd)
  );

  iraf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!empty),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .allowed_o   (allowed),
    .status_o    (status)
  );

  assign m_axis_tdata = {5'b0, status, allowed};

endmodule

`default_nettype wire

FILE: hdl/iraf_front.sv
// Front end: normalises and classifies incoming items into back-end commands.
`default_nettype none

module iraf_front (
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [1:0]                 op_i,
  input  logic                       family_i,
  input  logic [63:0]                addr_hi_i,
  input  logic [63:0]                addr_lo_i,
  input  logic [63:0]                end_hi_i,
  input  logic [63:0]                end_lo_i,
  input  logic [7:0]                 prefix_len_i,
  input  logic                       full_i,
  output logic                       push_o,
  output iraf_pkg::cmd_t             cmd_o
);
  import iraf_pkg::*;

  logic              fam;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] end_v;
  logic [ADDR_W-1:0] mask;
  logic [ADDR_W-1:0] fam_ones;
  logic [ADDR_W-1:0] pre_lo;
  logic [ADDR_W-1:0] pre_hi;
  logic [ADDR_W-1:0] lo_v;
  logic [ADDR_W-1:0] hi_v;
  logic              plen_bad;
  logic              swap;

  assign ready_o = !full_i;
  assign push_o  = valid_i && !full_i;

  always_comb begin
    fam   = family_i;
    addr  = {addr_hi_i, addr_lo_i};
    end_v = {end_hi_i, end_lo_i};
    if (!fam) begin
      addr  = {{(ADDR_W-V4_W){1'b0}}, addr_lo_i[V4_W-1:0]};
      end_v = {{(ADDR_W-V4_W){1'b0}}, end_lo_i[V4_W-1:0]};
    end
    // A mapped IPv6 address is looked up among the IPv4 rules.
    if (op_e'(op_i) == OP_CHECK && fam && addr[ADDR_W-1:HALF_W] == '0 &&
        addr[HALF_W-1:V4_W] == MAPPED_TAG) begin
      fam  = 1'b0;
      addr = {{(ADDR_W-V4_W){1'b0}}, addr[V4_W-1:0]};
    end

    // Shifts of the full word by at least its width give zero, so a full
    // prefix yields a mask of all ones.
    if (fam) begin
      fam_ones = '1;
      mask     = ~({ADDR_W{1'b1}} >> prefix_len_i);
      plen_bad = prefix_len_i > PLEN_MAX_V6;
    end else begin
      fam_ones = {{(ADDR_W-V4_W){1'b0}}, {V4_W{1'b1}}};
      mask     = {{(ADDR_W-V4_W){1'b0}}, ~({V4_W{1'b1}} >> prefix_len_i)};
      plen_bad = prefix_len_i > PLEN_MAX_V4;
    end
    pre_lo = addr & mask;
    pre_hi = pre_lo | (~mask & fam_ones);

    if (op_e'(op_i) == OP_ADD_PREFIX) begin
      lo_v = pre_lo;
      hi_v = pre_hi;
    end else begin
      lo_v = addr;
      hi_v = end_v;
    end
    swap = (op_e'(op_i) != OP_CHECK) && (lo_v > hi_v);

    cmd_o.rule.family = fam;
    cmd_o.rule.lo     = swap ? hi_v : lo_v;
    cmd_o.rule.hi     = swap ? lo_v : hi_v;

    case (op_e'(op_i))
      OP_CHECK:      cmd_o.kind = CMD_CHECK;
      OP_ADD_RANGE:  cmd_o.kind = CMD_ADD;
      OP_ADD_PREFIX: cmd_o.kind = plen_bad ? CMD_REJECT : CMD_ADD;
      OP_ALLOW_ALL:  cmd_o.kind = CMD_ALLOW;
      default:       cmd_o.kind = CMD_CHECK;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/iraf_fifo.sv
// Short command queue between the front end and the back end.
`default_nettype none

module iraf_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  iraf_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output iraf_pkg::cmd_t data_o
);
  import iraf_pkg::*;

  cmd_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic                  do_push;
  logic                  do_pop;

  assign full_o  = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 :
                 wr_ptr_q + FIFO_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 :
                 rd_ptr_q + FIFO_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + FIFO_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  ap_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("command queue holds more entries than its depth");

  ap_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty command queue with unequal pointers");

  ap_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + FIFO_CNT_W'(1)))
    else $error("push without pop did not grow the command queue");

endmodule

`default_nettype wire

FILE: hdl/iraf_back.sv
// Back end: rule table, allow-all flag, table walk for checks and result register.
`default_nettype none

module iraf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  iraf_pkg::cmd_t cmd_i,
  output logic           pop_o,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  output logic           allowed_o,
  output logic [1:0]     status_o
);
  import iraf_pkg::*;

  rule_t             table_mem [RULE_SLOTS];
  rule_t             rd_q;
  logic [IDX_W-1:0]  rd_addr;
  logic              mem_we;

  state_e            state_q, state_d;
  cmd_t              cmd_q;
  logic [CNT_W-1:0]  idx_q;
  logic [CNT_W-1:0]  idx_nxt;
  logic [CNT_W-1:0]  count_q;
  logic              allow_all_q;
  logic              res_allowed_q;
  status_e           res_status_q;
  logic              out_valid_q;
  logic              out_allowed_q;
  status_e           out_status_q;

  logic              start_walk;
  logic              hit;
  logic              last;
  logic              slot_free;
  logic              out_load;

  assign idx_nxt    = idx_q + CNT_W'(1);
  assign last       = (idx_nxt == count_q);
  assign hit        = (rd_q.family == cmd_q.rule.family) &&
                      (rd_q.lo <= cmd_q.rule.lo) && (cmd_q.rule.lo <= rd_q.hi);
  assign start_walk = (cmd_i.kind == CMD_CHECK) && !allow_all_q && (count_q != '0);
  assign slot_free  = !out_valid_q || m_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          state_d = start_walk ? ST_WALK : ST_REPLY;
        end
      end
      ST_WALK: begin
        if (hit || last) begin
          state_d = ST_REPLY;
        end
      end
      ST_REPLY: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    pop_o    = 1'b0;
    mem_we   = 1'b0;
    rd_addr  = '0;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        pop_o  = cmd_valid_i;
        mem_we = cmd_valid_i && (cmd_i.kind == CMD_ADD) &&
                 (count_q != CNT_W'(RULE_SLOTS));
      end
      ST_WALK: begin
        // Entry idx+1 is fetched while entry idx is compared.
        rd_addr = idx_nxt[IDX_W-1:0];
      end
      ST_REPLY: begin
        out_load = slot_free;
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[count_q[IDX_W-1:0]] <= cmd_i.rule;
    end
    rd_q <= table_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      count_q       <= '0;
      allow_all_q   <= 1'b1;
      idx_q         <= '0;
      out_valid_q   <= 1'b0;
      res_allowed_q <= 1'b0;
      res_status_q  <= STAT_OK;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        cmd_q <= cmd_i;
        idx_q <= '0;
        case (cmd_i.kind)
          CMD_CHECK: begin
            res_allowed_q <= allow_all_q;
            res_status_q  <= STAT_OK;
          end
          CMD_ADD: begin
            allow_all_q   <= 1'b0;
            res_allowed_q <= 1'b0;
            if (count_q == CNT_W'(RULE_SLOTS)) begin
              res_status_q <= STAT_FULL;
            end else begin
              res_status_q <= STAT_OK;
              count_q      <= count_q + CNT_W'(1);
            end
          end
          CMD_REJECT: begin
            allow_all_q   <= 1'b0;
            res_allowed_q <= 1'b0;
            res_status_q  <= STAT_BAD_PREFIX;
          end
          CMD_ALLOW: begin
            allow_all_q   <= 1'b1;
            count_q       <= '0;
            res_allowed_q <= 1'b0;
            res_status_q  <= STAT_OK;
          end
          default: begin
            res_allowed_q <= 1'b0;
            res_status_q  <= STAT_OK;
          end
        endcase
      end
      if (state_q == ST_WALK) begin
        idx_q <= idx_nxt;
        if (hit) begin
          res_allowed_q <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_allowed_q <= res_allowed_q;
      out_status_q  <= res_status_q;
    end
  end

  assign m_valid_o = out_valid_q;
  assign allowed_o = out_allowed_q;
  assign status_o  = out_status_q;

  ap_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(RULE_SLOTS))
    else $error("rule count exceeds the table size");

  ap_walk_needs_rules: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (!allow_all_q && idx_q < count_q))
    else $error("table walk past the stored rules or with allow-all set");

  ap_allow_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && cmd_i.kind == CMD_ALLOW) |=> (allow_all_q && count_q == '0))
    else $error("allow-all did not empty the table");

  ap_error_denies: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_allowed_q && out_status_q != STAT_OK))
    else $error("result permitted with an error status");

endmodule

`default_nettype wire
